>>> hdl/shp2_pkg.sv
// Shared constants, types and helpers of the SH order-2 projection block.
`default_nettype none
package shp2_pkg;

    localparam int ACC_WIDTH = 48;
    localparam int MAX_SIDE  = 4096;
    localparam int SIDE_W    = 13;
    localparam int CNT_W     = $clog2(MAX_SIDE);
    localparam int COLOR_W   = 32;
    localparam int OUT_W     = 48;
    localparam int NCOEF     = 27;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [SIDE_W-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [SIDE_W-1:0] RST_HEIGHT = 13'd512;

    // sine polynomial, Q30
    localparam logic [31:0] S1  = 32'd1686629713;
    localparam logic [31:0] S3  = 32'd693598668;
    localparam logic [31:0] S5  = 32'd85569306;
    localparam logic [31:0] S7  = 32'd5026995;
    localparam logic [31:0] S9  = 32'd172272;
    localparam logic [31:0] S11 = 32'd3864;

    localparam logic signed [32:0] Q30ONE = 33'sd1073741824;
    localparam logic signed [32:0] SHC0   = 33'sd302897200;
    localparam logic signed [32:0] SHC1   = 33'sd524633476;
    localparam logic signed [32:0] SHC2   = 33'sd1173114482;
    localparam logic signed [32:0] SHC3   = 33'sd338649581;
    localparam logic signed [32:0] SHC4   = 33'sd586557241;
    localparam logic [31:0] TWO_PI_SQ_Q26 = 32'd1324675879;

    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
    } t_dims;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic               last;
    } t_pix;

    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/shp2_fifo.sv
// Two-entry queue between the pixel front and the projection back.
`default_nettype none
module shp2_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire shp2_pkg::t_pix i_data,
    output logic               o_not_full,
    input  wire logic          i_pop,
    output shp2_pkg::t_pix     o_data,
    output logic               o_valid
);
    shp2_pkg::t_pix r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_not_full = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> hdl/shp2_front.sv
// Pixel front: tracks column and row and marks the frame's last pixel.
`default_nettype none
module shp2_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire shp2_pkg::t_dims             i_dims,
    input  wire logic                        i_clear,
    input  wire logic                        i_valid,
    input  wire logic                        i_fifo_ready,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_red,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_green,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_blue,
    output logic                             o_push,
    output shp2_pkg::t_pix                   o_item
);
    logic [shp2_pkg::CNT_W-1:0]  r_col;
    logic [shp2_pkg::CNT_W-1:0]  r_row;
    logic [shp2_pkg::SIDE_W-1:0] col1;
    logic [shp2_pkg::SIDE_W-1:0] row1;
    logic                        wrap;
    logic                        frame_end;

    always_comb begin
        col1      = shp2_pkg::SIDE_W'(r_col) + shp2_pkg::SIDE_W'(1);
        row1      = shp2_pkg::SIDE_W'(r_row) + shp2_pkg::SIDE_W'(1);
        wrap      = (col1 >= i_dims.w);
        frame_end = wrap && (row1 >= i_dims.h);
    end

    assign o_push       = i_valid && i_fifo_ready;
    assign o_item.red   = i_red;
    assign o_item.green = i_green;
    assign o_item.blue  = i_blue;
    assign o_item.col   = r_col;
    assign o_item.row   = r_row;
    assign o_item.last  = frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= row1[shp2_pkg::CNT_W-1:0];
            end else begin
                r_col <= col1[shp2_pkg::CNT_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/shp2_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`default_nettype none
module shp2_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[63]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], ge};
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/shp2_back.sv
// Projection back: angles, sines, basis, weight, 27 accumulators and result output.
`default_nettype none
module shp2_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire shp2_pkg::t_dims            i_dims,
    input  wire logic                       i_clear,
    input  wire shp2_pkg::t_pix             i_item,
    input  wire logic                       i_item_valid,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [1:0]                      o_channel,
    output logic [3:0]                      o_coeff_index,
    output logic signed [shp2_pkg::OUT_W-1:0] o_coeff_value,
    output logic                            o_last
);
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIV_TH = 8'b0000_0010,
        ST_DIV_PH = 8'b0000_0100,
        ST_SIN    = 8'b0000_1000,
        ST_BASIS  = 8'b0001_0000,
        ST_WDIV   = 8'b0010_0000,
        ST_ACC    = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

    localparam int AW = shp2_pkg::ACC_WIDTH;
    localparam logic signed [65:0] ACC_HI = 66'sd1 <<< (AW - 1);
    localparam logic signed [65:0] OUT_HI = 66'sd1 <<< (shp2_pkg::OUT_W - 1);

    t_state r_state;
    logic [shp2_pkg::COLOR_W-1:0] r_color [3];
    logic [shp2_pkg::CNT_W-1:0]   r_row;
    logic [shp2_pkg::CNT_W-1:0]   r_col;
    logic                         r_last;
    logic [31:0] r_ath;
    logic [31:0] r_aph;
    logic [1:0]  r_sidx;
    logic [2:0]  r_sstep;
    logic [31:0] r_p;
    logic [31:0] r_t2;
    logic signed [32:0] r_sin [4];
    logic [3:0]  r_mstep;
    logic signed [32:0] r_v [15];
    logic [63:0] r_wnum;
    logic [63:0] r_wt;
    logic [63:0] r_cb;
    logic [127:0] r_prod;
    logic [2:0]  r_astep;
    logic [1:0]  r_c;
    logic [3:0]  r_i;
    logic [4:0]  r_k;
    logic        r_div_start;
    logic [2*shp2_pkg::SIDE_W-1:0] r_wh;
    logic signed [AW-1:0] r_acc [shp2_pkg::NCOEF];
    logic        r_ov;
    logic [1:0]  r_och;
    logic [3:0]  r_oidx;
    logic signed [shp2_pkg::OUT_W-1:0] r_oval;
    logic        r_olast;

    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_q;

    logic [31:0] ang;
    logic [30:0] t_q;
    logic [31:0] coef;
    logic [33:0] sin_raw;
    logic [30:0] sin_mag;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic        flip;
    logic        mq_neg;
    logic signed [32:0] mq_res;
    logic signed [34:0] yy_x;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic signed [32:0] cur_b;
    logic [49:0] tm;
    logic signed [65:0] term;
    logic signed [65:0] acc_sum;
    logic signed [AW-1:0] acc_new;
    logic signed [65:0] acc_rd;
    logic signed [shp2_pkg::OUT_W-1:0] out_sat;
    logic        load_out;
    logic [31:0] sm;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    shp2_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // divider operands follow the state that owns the pass
    always_comb begin
        div_dividend = r_wnum;
        div_divisor  = 32'(r_wh);
        priority case (1'b1)
            r_state == ST_DIV_TH: begin
                div_dividend = {19'd0, r_row, 1'b1, 32'd0};
                div_divisor  = 32'({i_dims.h, 2'b00});
            end
            r_state == ST_DIV_PH: begin
                div_dividend = {19'd0, r_col, 1'b1, 32'd0};
                div_divisor  = 32'({i_dims.w, 1'b0});
            end
            default: ;
        endcase
    end

    // sine argument fold
    always_comb begin
        unique case (r_sidx)
            2'd0: ang = r_ath;
            2'd1: ang = r_ath + 32'h4000_0000;
            2'd2: ang = r_aph;
            2'd3: ang = r_aph + 32'h4000_0000;
            default: ang = r_ath;
        endcase
        t_q = ang[30] ? (31'h4000_0000 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
        unique case (r_sstep)
            3'd1: coef = shp2_pkg::S9;
            3'd2: coef = shp2_pkg::S7;
            3'd3: coef = shp2_pkg::S5;
            3'd4: coef = shp2_pkg::S3;
            3'd5: coef = shp2_pkg::S1;
            default: coef = shp2_pkg::S11;
        endcase
    end

    // basis step operands: dx dz c2dx c2dy yy xx zz then b1..b8
    always_comb begin
        yy_x = 35'(r_v[4]);
        op_a = 33'sd0;
        op_b = 33'sd0;
        flip = 1'b0;
        unique case (r_mstep)
            4'd0:  begin op_a = r_sin[0]; op_b = r_sin[2]; end
            4'd1:  begin op_a = r_sin[0]; op_b = r_sin[3]; end
            4'd2:  begin op_a = shp2_pkg::SHC2; op_b = r_v[0]; end
            4'd3:  begin op_a = shp2_pkg::SHC2; op_b = r_sin[1]; end
            4'd4:  begin op_a = r_sin[1]; op_b = r_sin[1]; end
            4'd5:  begin op_a = r_v[0]; op_b = r_v[0]; end
            4'd6:  begin op_a = r_v[1]; op_b = r_v[1]; end
            4'd7:  begin op_a = shp2_pkg::SHC1; op_b = r_sin[1]; flip = 1'b1; end
            4'd8:  begin op_a = shp2_pkg::SHC1; op_b = r_v[1]; end
            4'd9:  begin op_a = shp2_pkg::SHC1; op_b = r_v[0]; flip = 1'b1; end
            4'd10: begin op_a = r_v[2]; op_b = r_sin[1]; end
            4'd11: begin op_a = r_v[3]; op_b = r_v[1]; flip = 1'b1; end
            4'd12: begin
                op_a = shp2_pkg::SHC3;
                op_b = 33'(yy_x + yy_x + yy_x - 35'(shp2_pkg::Q30ONE));
            end
            4'd13: begin op_a = r_v[2]; op_b = r_v[1]; flip = 1'b1; end
            4'd14: begin
                op_a = shp2_pkg::SHC4;
                op_b = 33'(35'(r_v[5]) - 35'(r_v[6]));
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_i)
            4'd0:    cur_b = shp2_pkg::SHC0;
            4'd1:    cur_b = r_v[7];
            4'd2:    cur_b = r_v[8];
            4'd3:    cur_b = r_v[9];
            4'd4:    cur_b = r_v[10];
            4'd5:    cur_b = r_v[11];
            4'd6:    cur_b = r_v[12];
            4'd7:    cur_b = r_v[13];
            default: cur_b = r_v[14];
        endcase
        sm = r_sin[0][32] ? 32'd0 : r_sin[0][31:0];
    end

    // the one shared 32x32 multiplier
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        priority case (1'b1)
            r_state == ST_SIN: begin
                if (r_sstep == 3'd0) begin
                    mul_a = 32'(t_q);
                    mul_b = 32'(t_q);
                end else if (r_sstep == 3'd6) begin
                    mul_a = r_p;
                    mul_b = 32'(t_q);
                end else begin
                    mul_a = r_p;
                    mul_b = r_t2;
                end
            end
            r_state == ST_BASIS: begin
                if (r_mstep == 4'd15) begin
                    mul_a = sm;
                    mul_b = shp2_pkg::TWO_PI_SQ_Q26;
                end else begin
                    mul_a = mag33(op_a);
                    mul_b = mag33(op_b);
                end
            end
            r_state == ST_ACC: begin
                unique case (r_astep)
                    3'd0: begin mul_a = r_color[r_c]; mul_b = mag33(cur_b); end
                    3'd1: begin mul_a = r_cb[31:0];  mul_b = r_wt[31:0];  end
                    3'd2: begin mul_a = r_cb[31:0];  mul_b = r_wt[63:32]; end
                    3'd3: begin mul_a = r_cb[63:32]; mul_b = r_wt[31:0];  end
                    3'd4: begin mul_a = r_cb[63:32]; mul_b = r_wt[63:32]; end
                    default: ;
                endcase
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        sin_raw = mul_p[63:30];
        sin_mag = (sin_raw > 34'(shp2_pkg::Q30ONE)) ? 31'h4000_0000 : sin_raw[30:0];
        mq_neg  = op_a[32] ^ op_b[32] ^ flip;
        mq_res  = mq_neg ? -$signed({1'b0, mul_p[61:30]}) : $signed({1'b0, mul_p[61:30]});
    end

    // saturating accumulate and output clamp
    always_comb begin
        tm      = r_prod[127:78];
        term    = cur_b[32] ? -$signed(66'(tm)) : $signed(66'(tm));
        acc_rd  = 66'(r_acc[r_k]);
        acc_sum = acc_rd + term;
        if (acc_sum > ACC_HI - 66'sd1) begin
            acc_new = AW'(ACC_HI - 66'sd1);
        end else if (acc_sum < -ACC_HI) begin
            acc_new = AW'(-ACC_HI);
        end else begin
            acc_new = AW'(acc_sum);
        end
        if (acc_rd > OUT_HI - 66'sd1) begin
            out_sat = shp2_pkg::OUT_W'(OUT_HI - 66'sd1);
        end else if (acc_rd < -OUT_HI) begin
            out_sat = shp2_pkg::OUT_W'(-OUT_HI);
        end else begin
            out_sat = shp2_pkg::OUT_W'(acc_rd);
        end
    end

    assign o_pop    = (r_state == ST_IDLE) && i_item_valid;
    assign load_out = (r_state == ST_EMIT) && (!r_ov || i_ready);

    assign o_valid       = r_ov;
    assign o_channel     = r_och;
    assign o_coeff_index = r_oidx;
    assign o_coeff_value = r_oval;
    assign o_last        = r_olast;

    always_ff @(posedge i_clk) begin
        r_wh <= {{shp2_pkg::SIDE_W{1'b0}}, i_dims.w} * {{shp2_pkg::SIDE_W{1'b0}}, i_dims.h};
        if (o_pop) begin
            r_color[0] <= i_item.red;
            r_color[1] <= i_item.green;
            r_color[2] <= i_item.blue;
            r_row      <= i_item.row;
            r_col      <= i_item.col;
            r_last     <= i_item.last;
        end
        if (r_state == ST_DIV_TH && div_done) r_ath <= div_q[31:0];
        if (r_state == ST_DIV_PH && div_done) r_aph <= div_q[31:0];
        if (r_state == ST_SIN) begin
            if (r_sstep == 3'd0) begin
                r_t2 <= mul_p[61:30];
                r_p  <= shp2_pkg::S11;
            end else if (r_sstep == 3'd6) begin
                r_sin[r_sidx] <= ang[31] ? -$signed({2'b00, sin_mag})
                                         :  $signed({2'b00, sin_mag});
            end else begin
                r_p <= coef - mul_p[61:30];
            end
        end
        if (r_state == ST_BASIS) begin
            if (r_mstep == 4'd15) begin
                r_wnum <= mul_p;
            end else begin
                r_v[r_mstep] <= mq_res;
            end
        end
        if (r_state == ST_WDIV && div_done) r_wt <= div_q;
        if (r_state == ST_ACC) begin
            unique case (r_astep)
                3'd0: begin r_cb <= mul_p; r_prod <= '0; end
                3'd1: r_prod <= r_prod + {64'd0, mul_p};
                3'd2: r_prod <= r_prod + {32'd0, mul_p, 32'd0};
                3'd3: r_prod <= r_prod + {32'd0, mul_p, 32'd0};
                3'd4: r_prod <= r_prod + {mul_p, 64'd0};
                default: ;
            endcase
        end
        if (load_out) begin
            r_och   <= r_c;
            r_oidx  <= r_i;
            r_oval  <= out_sat;
            r_olast <= (r_k == 5'(shp2_pkg::NCOEF - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_sidx      <= '0;
            r_sstep     <= '0;
            r_mstep     <= '0;
            r_astep     <= '0;
            r_c         <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_ov        <= 1'b0;
            for (int n = 0; n < shp2_pkg::NCOEF; n++) r_acc[n] <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_clear) begin
                for (int n = 0; n < shp2_pkg::NCOEF; n++) r_acc[n] <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_TH;
                    end
                end
                ST_DIV_TH: begin
                    if (div_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV_PH;
                    end
                end
                ST_DIV_PH: begin
                    if (div_done) begin
                        r_sidx  <= '0;
                        r_sstep <= '0;
                        r_state <= ST_SIN;
                    end
                end
                ST_SIN: begin
                    if (r_sstep == 3'd6) begin
                        r_sstep <= '0;
                        if (r_sidx == 2'd3) begin
                            r_mstep <= '0;
                            r_state <= ST_BASIS;
                        end else begin
                            r_sidx <= r_sidx + 2'd1;
                        end
                    end else begin
                        r_sstep <= r_sstep + 3'd1;
                    end
                end
                ST_BASIS: begin
                    if (r_mstep == 4'd15) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_WDIV;
                    end else begin
                        r_mstep <= r_mstep + 4'd1;
                    end
                end
                ST_WDIV: begin
                    if (div_done) begin
                        r_astep <= '0;
                        r_c     <= '0;
                        r_i     <= '0;
                        r_k     <= '0;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (r_astep == 3'd5) begin
                        r_astep    <= '0;
                        r_acc[r_k] <= acc_new;
                        if (r_k == 5'(shp2_pkg::NCOEF - 1)) begin
                            r_c     <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_state <= r_last ? ST_EMIT : ST_IDLE;
                        end else begin
                            r_k <= r_k + 5'd1;
                            if (r_i == 4'd8) begin
                                r_i <= '0;
                                r_c <= r_c + 2'd1;
                            end else begin
                                r_i <= r_i + 4'd1;
                            end
                        end
                    end else begin
                        r_astep <= r_astep + 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (load_out) begin
                        if (r_k == 5'(shp2_pkg::NCOEF - 1)) begin
                            // last coefficient captured: clear the store
                            for (int n = 0; n < shp2_pkg::NCOEF; n++) r_acc[n] <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + 5'd1;
                            if (r_i == 4'd8) begin
                                r_i <= '0;
                                r_c <= r_c + 2'd1;
                            end else begin
                                r_i <= r_i + 4'd1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> (r_och == 2'd2 && r_oidx == 4'd8))
        else $error("last flag on a result other than blue coefficient 8");

    a_start_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == ST_DIV_TH || r_state == ST_DIV_PH
                         || r_state == ST_WDIV))
        else $error("divider started outside a division pass");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 5'(shp2_pkg::NCOEF - 1))
        else $error("accumulator index beyond the store");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_DIV_TH && r_div_start))
        else $error("item popped without starting the angle division");
endmodule
`default_nettype wire

>>> hdl/sh_projection_order2.sv
// Top level: config registers, pixel front, item queue and projection back.
//
//  channel   | handshake               | payload
//  pixel in  | i_valid / o_ready       | i_red, i_green, i_blue (Q16.16)
//  result    | o_valid / i_ready       | o_channel, o_coeff_index, o_coeff_value, o_last
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// In the back, a pixel takes three divider passes (two angles, one weight), four sine
// evaluations and the basis steps, then 27 multiply-accumulates; all but the divider
// passes run on one shared 32x32 multiplier.
// The frame's last pixel then emits 27 results, held while i_ready is low.
// Reset and any width or height write clear counters and accumulators at once.
// The two-entry queue takes pixels while it has room, also while the back works or results stall.
`default_nettype none
module sh_projection_order2 (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_red,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_green,
    input  wire logic [shp2_pkg::COLOR_W-1:0] i_blue,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [1:0]                        o_channel,
    output logic [3:0]                        o_coeff_index,
    output logic signed [shp2_pkg::OUT_W-1:0] o_coeff_value,
    output logic                              o_last,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [shp2_pkg::SIDE_W-1:0]  i_cfg_data
);
    logic [shp2_pkg::SIDE_W-1:0] r_cfg_w;
    logic [shp2_pkg::SIDE_W-1:0] r_cfg_h;
    shp2_pkg::t_dims dims;
    logic            clear;
    logic            fifo_ready;
    logic            push;
    shp2_pkg::t_pix  front_item;
    shp2_pkg::t_pix  q_item;
    logic            q_valid;
    logic            pop;

    assign o_cfg_ready = 1'b1;
    assign clear  = i_cfg_valid && (i_cfg_index == shp2_pkg::CFG_WIDTH
                                    || i_cfg_index == shp2_pkg::CFG_HEIGHT);
    assign dims.w = shp2_pkg::eff_side(r_cfg_w);
    assign dims.h = shp2_pkg::eff_side(r_cfg_h);
    assign o_ready = fifo_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= shp2_pkg::RST_WIDTH;
            r_cfg_h <= shp2_pkg::RST_HEIGHT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == shp2_pkg::CFG_WIDTH)  r_cfg_w <= i_cfg_data;
            if (i_cfg_index == shp2_pkg::CFG_HEIGHT) r_cfg_h <= i_cfg_data;
        end
    end

    shp2_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dims       (dims),
        .i_clear      (clear),
        .i_valid      (i_valid),
        .i_fifo_ready (fifo_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_push       (push),
        .o_item       (front_item)
    );

    shp2_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (front_item),
        .o_not_full (fifo_ready),
        .i_pop      (pop),
        .o_data     (q_item),
        .o_valid    (q_valid)
    );

    shp2_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dims        (dims),
        .i_clear       (clear),
        .i_item        (q_item),
        .i_item_valid  (q_valid),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_channel     (o_channel),
        .o_coeff_index (o_coeff_index),
        .o_coeff_value (o_coeff_value),
        .o_last        (o_last)
    );
endmodule
`default_nettype wire

>>> test/tb_sh_projection_order2.sv
// Self-checking bench for the SH order-2 projection block, with its own coefficient predictor.
module tb_sh_projection_order2;

    localparam logic [1:0] CFG_SPARE2 = 2'd2;
    localparam logic [1:0] CFG_SPARE3 = 2'd3;
    localparam int SETTLE = 1500;

    typedef struct {
        logic [1:0]                 channel;
        logic [3:0]                 index;
        logic [shp2_pkg::OUT_W-1:0] value;
        logic                       last;
    } t_coeff;

    class t_coeff_scoreboard;
        longint acc [shp2_pkg::NCOEF];
        bit [63:0] col, row;
        bit [shp2_pkg::SIDE_W-1:0] width_reg, height_reg;
        t_coeff coeff_due [$];
        int mismatches, checked, pixels, writes;

        function new();
            width_reg = shp2_pkg::RST_WIDTH;
            height_reg = shp2_pkg::RST_HEIGHT;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (acc[k]) acc[k] = 0;
            col = 0;
            row = 0;
        endfunction

        function bit [63:0] side(bit [shp2_pkg::SIDE_W-1:0] v);
            return (v == 0) ? 64'd1 : ((v > shp2_pkg::MAX_SIDE) ? 64'(shp2_pkg::MAX_SIDE)
                                                                : 64'(v));
        endfunction

        function bit [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint mul_q30(longint a, longint b);
            bit [63:0] m;
            m = (mag(a) * mag(b)) >> 30;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        // quarter-wave polynomial on a Q0.32 turn
        function longint sine(bit [31:0] a);
            bit [63:0] f, t, t2, p;
            f = 64'(a[29:0]);
            t = a[30] ? (64'd1 << 30) - f : f;
            t2 = (t * t) >> 30;
            p = 64'(shp2_pkg::S11);
            p = 64'(shp2_pkg::S9) - ((p * t2) >> 30);
            p = 64'(shp2_pkg::S7) - ((p * t2) >> 30);
            p = 64'(shp2_pkg::S5) - ((p * t2) >> 30);
            p = 64'(shp2_pkg::S3) - ((p * t2) >> 30);
            p = 64'(shp2_pkg::S1) - ((p * t2) >> 30);
            p = (p * t) >> 30;
            if (p > (64'd1 << 30)) p = 64'd1 << 30;
            return a[31] ? -longint'(p) : longint'(p);
        endfunction

        function void write_reg(logic [1:0] idx, logic [shp2_pkg::SIDE_W-1:0] data);
            writes++;
            if (idx == shp2_pkg::CFG_WIDTH) width_reg = data;
            else if (idx == shp2_pkg::CFG_HEIGHT) height_reg = data;
            else return;
            clear_frame();
        endfunction

        function void take_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
            bit [63:0] w, h, c, rw, sm, wt, cb, color;
            bit [127:0] prod;
            bit [31:0] ath, aph;
            longint st, ct, sp, cp, dx, dy, dz, term, hi;
            longint basis [9];
            bit [31:0] rgb [3];
            t_coeff e;
            rgb[0] = r; rgb[1] = g; rgb[2] = b;
            pixels++;
            w = side(width_reg);
            h = side(height_reg);
            c = (col >= w) ? 0 : col;
            rw = (row >= h) ? 0 : row;
            ath = 32'(((2 * rw + 1) << 32) / (4 * h));
            aph = 32'(((2 * c + 1) << 32) / (2 * w));
            st = sine(ath);
            ct = sine(ath + 32'h4000_0000);
            sp = sine(aph);
            cp = sine(aph + 32'h4000_0000);
            dx = mul_q30(st, sp);
            dy = ct;
            dz = mul_q30(st, cp);
            basis[0] = shp2_pkg::SHC0;
            basis[1] = -mul_q30(shp2_pkg::SHC1, dy);
            basis[2] = mul_q30(shp2_pkg::SHC1, dz);
            basis[3] = -mul_q30(shp2_pkg::SHC1, dx);
            basis[4] = mul_q30(mul_q30(shp2_pkg::SHC2, dx), dy);
            basis[5] = -mul_q30(mul_q30(shp2_pkg::SHC2, dy), dz);
            basis[6] = mul_q30(shp2_pkg::SHC3,
                               3 * mul_q30(dy, dy) - longint'(shp2_pkg::Q30ONE));
            basis[7] = -mul_q30(mul_q30(shp2_pkg::SHC2, dx), dz);
            basis[8] = mul_q30(shp2_pkg::SHC4, mul_q30(dx, dx) - mul_q30(dz, dz));
            sm = st < 0 ? 0 : 64'(st);
            wt = (sm * 64'(shp2_pkg::TWO_PI_SQ_Q26)) / (w * h);
            hi = (longint'(1) << (shp2_pkg::ACC_WIDTH - 1)) - 1;
            for (int ch = 0; ch < 3; ch++) begin
                color = 64'(rgb[ch]);
                for (int i = 0; i < 9; i++) begin
                    cb = color * mag(basis[i]);
                    prod = {64'd0, cb} * {64'd0, wt};
                    term = longint'(prod[127:78]);
                    if (basis[i] < 0) term = -term;
                    // saturate at the accumulator width
                    if (term > 0 && acc[ch*9+i] > hi - term) acc[ch*9+i] = hi;
                    else if (term < 0 && acc[ch*9+i] < -hi - 1 - term) acc[ch*9+i] = -hi - 1;
                    else acc[ch*9+i] += term;
                end
            end
            c++;
            if (c >= w) begin
                c = 0;
                rw++;
            end
            col = c;
            row = rw;
            if (rw < h) return;
            for (int k = 0; k < shp2_pkg::NCOEF; k++) begin
                e.channel = 2'(k / 9);
                e.index = 4'(k % 9);
                e.value = shp2_pkg::OUT_W'(acc[k]);
                e.last = (k == shp2_pkg::NCOEF - 1);
                coeff_due.insert(coeff_due.size(), e);
            end
            clear_frame();
        endfunction

        function void check_coeff(logic [1:0] ch, logic [3:0] idx,
                                  logic [shp2_pkg::OUT_W-1:0] val, logic last);
            t_coeff e;
            checked++;
            if (coeff_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected coefficient ch=%0d idx=%0d val=%h", ch, idx, val);
                return;
            end
            e = coeff_due.pop_front();
            if (ch !== e.channel || idx !== e.index || val !== e.value || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp ch=%0d idx=%0d val=%h last=%0d,",
                              " got ch=%0d idx=%0d val=%h last=%0d"},
                             e.channel, e.index, e.value, e.last, ch, idx, val, last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [shp2_pkg::COLOR_W-1:0] i_red = '0, i_green = '0, i_blue = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_channel;
    logic [3:0] o_coeff_index;
    logic signed [shp2_pkg::OUT_W-1:0] o_coeff_value;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [shp2_pkg::SIDE_W-1:0] i_cfg_data = '0;

    t_coeff_scoreboard board = new();
    bit calm = 1'b0;
    int ready_hold = 0;

    sh_projection_order2 dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                board.check_coeff(o_channel, o_coeff_index, o_coeff_value, o_last);
                ready_hold = calm ? 0 : $urandom_range(0, 19);
            end
            if (i_valid && o_ready) board.take_pixel(i_red, i_green, i_blue);
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // stall the result side per item
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_ready = 1'b0;
            ready_hold--;
        end else begin
            i_ready = 1'b1;
        end
    end

    function logic [31:0] pick_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_red = r;
        i_green = g;
        i_blue = b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task settle();
        i_valid = 1'b0;
        while (board.coeff_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task write_cfg(logic [1:0] idx, logic [shp2_pkg::SIDE_W-1:0] data);
        settle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task set_size(int w, int h);
        write_cfg(shp2_pkg::CFG_WIDTH, shp2_pkg::SIDE_W'(w));
        write_cfg(shp2_pkg::CFG_HEIGHT, shp2_pkg::SIDE_W'(h));
    endtask

    initial begin
        #400_000_000;
        $display("[sh_projection_order2] ERROR");
        $finish;
    end

    initial begin
        int w, h, frames;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // default size: a partial frame only
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        set_size(1, 1);
        send_pixel('1, '1, '1);
        send_pixel('0, '1, '0);
        send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0F0F);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0);
        send_pixel(32'd1, 32'h8000_0000, 32'h0001_0000);
        // spare index leaves size and frame alone
        write_cfg(CFG_SPARE3, '1);
        send_pixel('1, '0, '1);
        // zero sizes act as one
        set_size(0, 0);
        send_pixel('1, '1, '1);
        send_pixel(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_0000);
        // oversize clamps; partial frame then restart
        set_size(8191, 8191);
        send_pixel('1, '1, '1);
        send_pixel(32'hDEAD_BEEF, '1, '0);
        set_size(2, 2);
        send_pixel('1, '1, '1);
        send_pixel('1, '0, '1);
        write_cfg(CFG_SPARE2, '0);
        send_pixel('0, '1, '1);
        send_pixel('1, '1, '1);
        set_size(1, 3);
        repeat (3) send_pixel('1, '1, '1);

        while (board.pixels < 305) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(4097, 8191) : $urandom_range(0, 5);
            h = $urandom_range(0, 4);
            calm = ($urandom_range(0, 3) == 0);
            set_size(w, h);
            if (w > 5) begin
                // huge frame: feed a few, abandon it
                repeat ($urandom_range(1, 4)) send_pixel(pick_color(), pick_color(), pick_color());
            end else begin
                if (w == 0) w = 1;
                if (h == 0) h = 1;
                frames = $urandom_range(1, 3);
                repeat (frames * w * h) send_pixel(pick_color(), pick_color(), pick_color());
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_pixel(pick_color(), pick_color(), pick_color());
            end
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d pixels and %0d coefficients over %0d register writes,",
                 board.pixels, board.checked, board.writes);
        $display("sizes from zero through clamped oversize, with random stalls on both sides.");
        if (board.mismatches == 0 && board.coeff_due.size() == 0) begin
            $display("[sh_projection_order2] OK");
        end else begin
            $display("%0d mismatches, %0d coefficients still due",
                     board.mismatches, board.coeff_due.size());
            $display("[sh_projection_order2] ERROR");
        end
        $finish;
    end
endmodule
